// ===== src/ppg_pkg.sv =====
// shared types and constants for the point plane ground classifier
`default_nettype none

package ppg_pkg;

    // field and register widths
    localparam int COORD_BITS     = 24;
    localparam int THRESH_BITS    = 20;
    localparam int CUT_BITS       = 24;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 24;

    // multiplier limb width
    localparam int LIMB_BITS = 32;

    // datapath widths, all exact
    localparam int DIFF_BITS     = COORD_BITS + 1;
    localparam int CROSS_BITS    = 2 * DIFF_BITS;
    localparam int NORM_BITS     = CROSS_BITS + 1;
    localparam int DOT_TERM_BITS = NORM_BITS + DIFF_BITS;
    localparam int DOT_BITS      = DOT_TERM_BITS + 3;
    localparam int SQ_BITS       = 2 * NORM_BITS;
    localparam int NN_BITS       = SQ_BITS + 2;
    localparam int S2_BITS       = 2 * DOT_BITS;
    localparam int TNN_BITS      = THRESH_BITS + NN_BITS;
    localparam int BOUND_BITS    = THRESH_BITS + TNN_BITS;
    localparam int CMP_BITS      = (S2_BITS > BOUND_BITS) ? S2_BITS : BOUND_BITS;
    localparam int CUT_CMP_BITS  = (COORD_BITS > CUT_BITS) ? COORD_BITS : CUT_BITS;

    // pipeline depth in register stages
    localparam int DEPTH       = 17;
    localparam int FRONT_DEPTH = 4;
    localparam int MUL_DEPTH   = 3;

    // register reset values
    localparam logic [THRESH_BITS-1:0]     DOOR_THRESHOLD_RESET = '0;
    localparam logic signed [CUT_BITS-1:0] CUT_HEIGHT_RESET     = {1'b0, {(CUT_BITS-1){1'b1}}};

    // configuration register indexes
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_DOOR_THRESHOLD = 2'd0,
        REG_CUT_HEIGHT     = 2'd1,
        REG_CUT_ENABLE     = 2'd2
    } cfg_reg_t;

    // request payload: triangle vertices and query point
    typedef struct packed {
        logic signed [COORD_BITS-1:0] ax;
        logic signed [COORD_BITS-1:0] ay;
        logic signed [COORD_BITS-1:0] az;
        logic signed [COORD_BITS-1:0] bx;
        logic signed [COORD_BITS-1:0] by;
        logic signed [COORD_BITS-1:0] bz;
        logic signed [COORD_BITS-1:0] cx;
        logic signed [COORD_BITS-1:0] cy;
        logic signed [COORD_BITS-1:0] cz;
        logic signed [COORD_BITS-1:0] px;
        logic signed [COORD_BITS-1:0] py;
        logic signed [COORD_BITS-1:0] pz;
    } req_t;

    // result payload
    typedef struct packed {
        logic is_ground;
        logic degenerate;
    } rsp_t;

    // normal and offset magnitudes leaving the geometry front end
    typedef struct packed {
        logic [2:0][NORM_BITS-1:0] n_mag;
        logic [2:0]                n_neg;
        logic [2:0][DIFF_BITS-1:0] d_mag;
        logic [2:0]                d_neg;
        logic                      degenerate;
        logic                      cut_ok;
    } front_t;

    // per-request flags carried alongside the wide datapath
    typedef struct packed {
        logic [2:0] neg;
        logic       degenerate;
        logic       cut_ok;
    } flags_t;

endpackage

`default_nettype wire

// ===== src/ppg_pipe_ctrl.sv =====
// valid bits and per-stage load enables of the classifier pipeline
`default_nettype none

module ppg_pipe_ctrl #(
    parameter int STAGES = 17
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic              out_ready,
    output logic                   in_ready,
    output logic [STAGES-1:0]      en,
    output logic [STAGES-1:0]      valid
);

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;

    // a stage loads when it or any stage after it holds a bubble, or the sink takes
    always_comb
    begin
        for (int k = 0; k < STAGES; k++)
        begin
            en[k] = out_ready || ((~valid_reg >> k) != '0);
        end
    end

    // valid bits move with the data
    always_comb
    begin
        valid_next = valid_reg;
        for (int k = 0; k < STAGES; k++)
        begin
            if (en[k])
            begin
                valid_next[k] = (k == 0) ? in_valid : valid_reg[(k == 0) ? 0 : k - 1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_ready = en[0];
    assign valid    = valid_reg;

endmodule

`default_nettype wire

// ===== src/ppg_front.sv =====
// geometry front end: edge vectors, cross product normal and magnitudes
`default_nettype none

module ppg_front (
    input  wire logic                              clk,
    input  wire logic [ppg_pkg::FRONT_DEPTH-1:0]   en,
    input  wire ppg_pkg::req_t                     req,
    input  wire logic signed [ppg_pkg::CUT_BITS-1:0] cut_height,
    input  wire logic                              cut_enable,
    output ppg_pkg::front_t                        geom
);

    localparam int DW = ppg_pkg::DIFF_BITS;
    localparam int CW = ppg_pkg::CROSS_BITS;
    localparam int NW = ppg_pkg::NORM_BITS;
    localparam int HW = ppg_pkg::CUT_CMP_BITS;

    // stage 1 registers
    logic signed [DW-1:0] u_reg [3];
    logic signed [DW-1:0] v_reg [3];
    logic signed [DW-1:0] d_reg [3];
    logic                 cut_ok1_reg;
    logic signed [DW-1:0] u_next [3];
    logic signed [DW-1:0] v_next [3];
    logic signed [DW-1:0] d_next [3];
    logic                 cut_ok1_next;

    // stage 2 registers
    logic signed [CW-1:0] cr_reg [6];
    logic signed [CW-1:0] cr_next [6];
    logic [2:0][DW-1:0]   d_mag2_reg;
    logic [2:0][DW-1:0]   d_mag2_next;
    logic [2:0]           d_neg2_reg;
    logic [2:0]           d_neg2_next;
    logic                 cut_ok2_reg;

    // stage 3 registers
    logic signed [NW-1:0] n_reg [3];
    logic signed [NW-1:0] n_next [3];
    logic [2:0][DW-1:0]   d_mag3_reg;
    logic [2:0]           d_neg3_reg;
    logic                 cut_ok3_reg;

    // stage 4 registers
    ppg_pkg::front_t      geom_reg;
    ppg_pkg::front_t      geom_next;

    // edge vectors from the first vertex and the cut height test
    always_comb
    begin
        u_next[0] = DW'(req.bx) - DW'(req.ax);
        u_next[1] = DW'(req.by) - DW'(req.ay);
        u_next[2] = DW'(req.bz) - DW'(req.az);
        v_next[0] = DW'(req.cx) - DW'(req.ax);
        v_next[1] = DW'(req.cy) - DW'(req.ay);
        v_next[2] = DW'(req.cz) - DW'(req.az);
        d_next[0] = DW'(req.px) - DW'(req.ax);
        d_next[1] = DW'(req.py) - DW'(req.ay);
        d_next[2] = DW'(req.pz) - DW'(req.az);
        cut_ok1_next = !cut_enable || (HW'(req.pz) < HW'(cut_height));
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            u_reg       <= u_next;
            v_reg       <= v_next;
            d_reg       <= d_next;
            cut_ok1_reg <= cut_ok1_next;
        end
    end

    // cross product partial terms and offset magnitudes
    always_comb
    begin
        cr_next[0] = CW'(u_reg[1]) * CW'(v_reg[2]);
        cr_next[1] = CW'(u_reg[2]) * CW'(v_reg[1]);
        cr_next[2] = CW'(u_reg[2]) * CW'(v_reg[0]);
        cr_next[3] = CW'(u_reg[0]) * CW'(v_reg[2]);
        cr_next[4] = CW'(u_reg[0]) * CW'(v_reg[1]);
        cr_next[5] = CW'(u_reg[1]) * CW'(v_reg[0]);
        for (int k = 0; k < 3; k++)
        begin
            d_neg2_next[k] = d_reg[k][DW-1];
            d_mag2_next[k] = d_reg[k][DW-1] ? DW'(-d_reg[k]) : DW'(d_reg[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            cr_reg      <= cr_next;
            d_mag2_reg  <= d_mag2_next;
            d_neg2_reg  <= d_neg2_next;
            cut_ok2_reg <= cut_ok1_reg;
        end
    end

    // normal components
    always_comb
    begin
        n_next[0] = NW'(cr_reg[0]) - NW'(cr_reg[1]);
        n_next[1] = NW'(cr_reg[2]) - NW'(cr_reg[3]);
        n_next[2] = NW'(cr_reg[4]) - NW'(cr_reg[5]);
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            n_reg       <= n_next;
            d_mag3_reg  <= d_mag2_reg;
            d_neg3_reg  <= d_neg2_reg;
            cut_ok3_reg <= cut_ok2_reg;
        end
    end

    // normal magnitudes, signs and the zero normal check
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            geom_next.n_neg[k] = n_reg[k][NW-1];
            geom_next.n_mag[k] = n_reg[k][NW-1] ? NW'(-n_reg[k]) : NW'(n_reg[k]);
        end
        geom_next.d_mag      = d_mag3_reg;
        geom_next.d_neg      = d_neg3_reg;
        geom_next.degenerate = (n_reg[0] == '0) && (n_reg[1] == '0) && (n_reg[2] == '0);
        geom_next.cut_ok     = cut_ok3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            geom_reg <= geom_next;
        end
    end

    assign geom = geom_reg;

endmodule

`default_nettype wire

// ===== src/ppg_umul.sv =====
// three-stage unsigned multiplier built from limb partial products
`default_nettype none

module ppg_umul #(
    parameter int A_BITS = 32,
    parameter int B_BITS = 32
) (
    input  wire logic                       clk,
    input  wire logic [ppg_pkg::MUL_DEPTH-1:0] en,
    input  wire logic [A_BITS-1:0]          a,
    input  wire logic [B_BITS-1:0]          b,
    output logic [A_BITS+B_BITS-1:0]        p
);

    localparam int LW        = ppg_pkg::LIMB_BITS;
    localparam int KA        = (A_BITS + LW - 1) / LW;
    localparam int KB        = (B_BITS + LW - 1) / LW;
    localparam int ROW_BITS  = LW * (KB + 1);
    localparam int FULL_BITS = LW * (KA + KB);
    localparam int P_BITS    = A_BITS + B_BITS;

    logic [KA*LW-1:0]    a_pad;
    logic [KB*LW-1:0]    b_pad;
    logic [2*LW-1:0]     pp_reg   [KA][KB];
    logic [2*LW-1:0]     pp_next  [KA][KB];
    logic [ROW_BITS-1:0] row_reg  [KA];
    logic [ROW_BITS-1:0] row_next [KA];
    logic [FULL_BITS-1:0] full_sum;
    logic [P_BITS-1:0]   p_reg;
    logic [P_BITS-1:0]   p_next;

    assign a_pad = (KA*LW)'(a);
    assign b_pad = (KB*LW)'(b);

    // limb by limb partial products
    always_comb
    begin
        for (int i = 0; i < KA; i++)
        begin
            for (int j = 0; j < KB; j++)
            begin
                pp_next[i][j] = (2*LW)'(a_pad[i*LW +: LW]) * (2*LW)'(b_pad[j*LW +: LW]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            pp_reg <= pp_next;
        end
    end

    // one row per limb of a
    always_comb
    begin
        for (int i = 0; i < KA; i++)
        begin
            row_next[i] = '0;
            for (int j = 0; j < KB; j++)
            begin
                row_next[i] = row_next[i] + (ROW_BITS'(pp_reg[i][j]) << (LW * j));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            row_reg <= row_next;
        end
    end

    // rows into the full product
    always_comb
    begin
        full_sum = '0;
        for (int i = 0; i < KA; i++)
        begin
            full_sum = full_sum + (FULL_BITS'(row_reg[i]) << (LW * i));
        end
        p_next = full_sum[P_BITS-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            p_reg <= p_next;
        end
    end

    assign p = p_reg;

endmodule

`default_nettype wire

// ===== src/point_plane_ground_classifier_core.sv =====
// throughput: one request per cycle while results are taken; every stage has its
// own load enable, so a stalled result holds only the full stages between it and
// the nearest bubble behind it, and bubbles are squeezed out
// the depth follows from the exact product chain, each wide product split into
// 32-bit limbs over a three-stage multiplier
// reset: valid bits clear, door_threshold 0, cut_height 8388607, cut_enable 0
`default_nettype none

module point_plane_ground_classifier_core (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  req_valid,
    output logic                                       req_ready,
    input  wire ppg_pkg::req_t                         req,
    output logic                                       rsp_valid,
    input  wire logic                                  rsp_ready,
    output ppg_pkg::rsp_t                              rsp,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [ppg_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  wire logic [ppg_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

    localparam int DEPTH       = ppg_pkg::DEPTH;
    localparam int NW          = ppg_pkg::NORM_BITS;
    localparam int DW          = ppg_pkg::DIFF_BITS;
    localparam int TW          = ppg_pkg::THRESH_BITS;
    localparam int DOTW        = ppg_pkg::DOT_BITS;
    localparam int DOT_TW      = ppg_pkg::DOT_TERM_BITS;
    localparam int SQW         = ppg_pkg::SQ_BITS;
    localparam int NNW         = ppg_pkg::NN_BITS;
    localparam int S2W         = ppg_pkg::S2_BITS;
    localparam int TNNW        = ppg_pkg::TNN_BITS;
    localparam int BW          = ppg_pkg::BOUND_BITS;
    localparam int CMPW        = ppg_pkg::CMP_BITS;
    localparam int FLAG_STAGES = 12;

    // configuration registers
    logic [TW-1:0]                          door_threshold_reg;
    logic signed [ppg_pkg::CUT_BITS-1:0]    cut_height_reg;
    logic                                   cut_enable_reg;

    // pipeline control
    logic [DEPTH-1:0] en;
    logic [DEPTH-1:0] stage_valid;

    // datapath between units
    ppg_pkg::front_t      geom;
    logic [DOT_TW-1:0]    dot_p [3];
    logic [SQW-1:0]       sq_p  [3];
    ppg_pkg::flags_t      flag_reg [FLAG_STAGES];

    logic signed [DOTW-1:0] term_reg  [3];
    logic signed [DOTW-1:0] term_next [3];
    logic [NNW-1:0]         nn8_reg;
    logic signed [DOTW-1:0] s_reg;
    logic [NNW-1:0]         nn9_reg;
    logic [DOTW-1:0]        s_mag_reg;
    logic [NNW-1:0]         nn10_reg;
    logic [S2W-1:0]         s2_p;
    logic [TNNW-1:0]        tnn_p;
    logic [BW-1:0]          bound_p;
    logic [S2W-1:0]         s2_dly_reg [3];
    ppg_pkg::rsp_t          rsp_reg;
    ppg_pkg::rsp_t          rsp_next;

    // configuration writes, always accepted
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            door_threshold_reg <= ppg_pkg::DOOR_THRESHOLD_RESET;
            cut_height_reg     <= ppg_pkg::CUT_HEIGHT_RESET;
            cut_enable_reg     <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                ppg_pkg::REG_DOOR_THRESHOLD: door_threshold_reg <= cfg_data[TW-1:0];
                ppg_pkg::REG_CUT_HEIGHT:     cut_height_reg <= cfg_data[ppg_pkg::CUT_BITS-1:0];
                ppg_pkg::REG_CUT_ENABLE:     cut_enable_reg <= cfg_data[0];
                default:                     ;
            endcase
        end
    end

    // valid bits and stage enables
    ppg_pipe_ctrl #(
        .STAGES (DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req_valid),
        .out_ready (rsp_ready),
        .in_ready  (req_ready),
        .en        (en),
        .valid     (stage_valid)
    );

    // stages 1 to 4: normal and offset magnitudes
    ppg_front u_front (
        .clk        (clk),
        .en         (en[3:0]),
        .req        (req),
        .cut_height (cut_height_reg),
        .cut_enable (cut_enable_reg),
        .geom       (geom)
    );

    // stages 5 to 7: plane value terms and normal squares
    for (genvar g = 0; g < 3; g++)
    begin : g_mul1
        ppg_umul #(
            .A_BITS (NW),
            .B_BITS (DW)
        ) u_dot (
            .clk (clk),
            .en  (en[6:4]),
            .a   (geom.n_mag[g]),
            .b   (geom.d_mag[g]),
            .p   (dot_p[g])
        );

        ppg_umul #(
            .A_BITS (NW),
            .B_BITS (NW)
        ) u_sq (
            .clk (clk),
            .en  (en[6:4]),
            .a   (geom.n_mag[g]),
            .b   (geom.n_mag[g]),
            .p   (sq_p[g])
        );
    end

    // flags travel with stages 5 to 16
    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            flag_reg[0].neg        <= geom.n_neg ^ geom.d_neg;
            flag_reg[0].degenerate <= geom.degenerate;
            flag_reg[0].cut_ok     <= geom.cut_ok;
        end
        for (int k = 1; k < FLAG_STAGES; k++)
        begin
            if (en[k + 4])
            begin
                flag_reg[k] <= flag_reg[k - 1];
            end
        end
    end

    // stage 8: signed plane terms and the squared normal length
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            term_next[k] = flag_reg[2].neg[k] ? -$signed(DOTW'(dot_p[k]))
                                              : $signed(DOTW'(dot_p[k]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[7])
        begin
            term_reg <= term_next;
            nn8_reg  <= NNW'(sq_p[0]) + NNW'(sq_p[1]) + NNW'(sq_p[2]);
        end
    end

    // stage 9: plane value
    always_ff @(posedge clk)
    begin
        if (en[8])
        begin
            s_reg   <= term_reg[0] + term_reg[1] + term_reg[2];
            nn9_reg <= nn8_reg;
        end
    end

    // stage 10: plane value magnitude
    always_ff @(posedge clk)
    begin
        if (en[9])
        begin
            s_mag_reg <= s_reg[DOTW-1] ? DOTW'(-s_reg) : DOTW'(s_reg);
            nn10_reg  <= nn9_reg;
        end
    end

    // stages 11 to 13: squared plane value and threshold times normal length
    ppg_umul #(
        .A_BITS (DOTW),
        .B_BITS (DOTW)
    ) u_s2 (
        .clk (clk),
        .en  (en[12:10]),
        .a   (s_mag_reg),
        .b   (s_mag_reg),
        .p   (s2_p)
    );

    ppg_umul #(
        .A_BITS (TW),
        .B_BITS (NNW)
    ) u_tnn (
        .clk (clk),
        .en  (en[12:10]),
        .a   (door_threshold_reg),
        .b   (nn10_reg),
        .p   (tnn_p)
    );

    // stages 14 to 16: squared threshold times normal length
    ppg_umul #(
        .A_BITS (TW),
        .B_BITS (TNNW)
    ) u_bound (
        .clk (clk),
        .en  (en[15:13]),
        .a   (door_threshold_reg),
        .b   (tnn_p),
        .p   (bound_p)
    );

    always_ff @(posedge clk)
    begin
        if (en[13])
        begin
            s2_dly_reg[0] <= s2_p;
        end
        if (en[14])
        begin
            s2_dly_reg[1] <= s2_dly_reg[0];
        end
        if (en[15])
        begin
            s2_dly_reg[2] <= s2_dly_reg[1];
        end
    end

    // stage 17: distance compare and result register
    always_comb
    begin
        rsp_next.degenerate = flag_reg[FLAG_STAGES-1].degenerate;
        rsp_next.is_ground  = !flag_reg[FLAG_STAGES-1].degenerate
                              && flag_reg[FLAG_STAGES-1].cut_ok
                              && (CMPW'(s2_dly_reg[2]) < CMPW'(bound_p));
    end

    always_ff @(posedge clk)
    begin
        if (en[16])
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp       = rsp_reg;
    assign rsp_valid = stage_valid[DEPTH-1];

`ifndef NO_ASSERTIONS
    // new requests are held off only when every stage is occupied
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !req_ready |-> (&stage_valid))
        else $error("request stalled while the pipeline has a bubble");

    // a degenerate triangle never yields a ground point
    a_degenerate_not_ground: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.degenerate |-> !rsp.is_ground)
        else $error("ground result for a degenerate triangle");

    // a result leaves the output only when it was taken
    a_result_not_dropped: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(rsp_valid) |-> $past(rsp_ready))
        else $error("result dropped without being taken");
`endif

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// testbench for the point plane ground classifier core
module tb;

    localparam int CMAX = 8388607;
    localparam int CMIN = -8388608;
    localparam int LONG_HOLD = 150;
    localparam int TIMEOUT_TIME = 400000;
    localparam logic [ppg_pkg::CFG_INDEX_BITS-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic [ppg_pkg::CFG_INDEX_BITS-1:0] index;
        logic [ppg_pkg::CFG_DATA_BITS-1:0]  data;
    } reg_write_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    ppg_pkg::req_t req = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    ppg_pkg::rsp_t rsp;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [ppg_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [ppg_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;

    // stimulus queues and expected verdicts
    ppg_pkg::req_t pending_points[$];
    reg_write_t pending_reg_writes[$];
    ppg_pkg::rsp_t expected_verdicts[$];

    // local copy of the configuration registers
    logic [ppg_pkg::THRESH_BITS-1:0] door_limit = ppg_pkg::DOOR_THRESHOLD_RESET;
    logic signed [ppg_pkg::CUT_BITS-1:0] cut_limit = ppg_pkg::CUT_HEIGHT_RESET;
    logic cut_on = 1'b0;

    int mismatches = 0;
    int sender_max_gap = 0;
    int receiver_max_gap = 0;
    int hold_requests = 0;
    int cur_spread = 50;

    int send_gap;
    int rsp_stall;
    int rsp_draw;
    int hold_left;
    int hold_seen;

    point_plane_ground_classifier_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // exact point to plane classification, compared as squares
    function automatic ppg_pkg::rsp_t classify_point(input ppg_pkg::req_t pt);
        logic signed [255:0] ux, uy, uz, vx, vy, vz, dx, dy, dz;
        logic signed [255:0] nx, ny, nz, offset, offset_sq, norm_sq, limit_sq;
        ppg_pkg::rsp_t verdict;
        ux = $signed(pt.bx) - $signed(pt.ax);
        uy = $signed(pt.by) - $signed(pt.ay);
        uz = $signed(pt.bz) - $signed(pt.az);
        vx = $signed(pt.cx) - $signed(pt.ax);
        vy = $signed(pt.cy) - $signed(pt.ay);
        vz = $signed(pt.cz) - $signed(pt.az);
        dx = $signed(pt.px) - $signed(pt.ax);
        dy = $signed(pt.py) - $signed(pt.ay);
        dz = $signed(pt.pz) - $signed(pt.az);
        nx = uy * vz - uz * vy;
        ny = uz * vx - ux * vz;
        nz = ux * vy - uy * vx;
        offset = nx * dx + ny * dy + nz * dz;
        offset_sq = offset * offset;
        norm_sq = nx * nx + ny * ny + nz * nz;
        limit_sq = door_limit * door_limit * norm_sq;
        verdict.degenerate = (nx == 0) && (ny == 0) && (nz == 0);
        verdict.is_ground = !verdict.degenerate && (offset_sq < limit_sq);
        if (cut_on && !($signed(pt.pz) < cut_limit))
            verdict.is_ground = 1'b0;
        return verdict;
    endfunction

    function automatic int pick_between(input int lo, input int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    function automatic int corner_value();
        case ($urandom_range(4))
            0: return CMIN;
            1: return CMAX;
            2: return 0;
            3: return -1;
            default: return 1;
        endcase
    endfunction

    task automatic queue_point(input int ax, input int ay, input int az,
                               input int bx, input int by, input int bz,
                               input int cx, input int cy, input int cz,
                               input int px, input int py, input int pz);
        ppg_pkg::req_t pt;
        pt.ax = ax[ppg_pkg::COORD_BITS-1:0];
        pt.ay = ay[ppg_pkg::COORD_BITS-1:0];
        pt.az = az[ppg_pkg::COORD_BITS-1:0];
        pt.bx = bx[ppg_pkg::COORD_BITS-1:0];
        pt.by = by[ppg_pkg::COORD_BITS-1:0];
        pt.bz = bz[ppg_pkg::COORD_BITS-1:0];
        pt.cx = cx[ppg_pkg::COORD_BITS-1:0];
        pt.cy = cy[ppg_pkg::COORD_BITS-1:0];
        pt.cz = cz[ppg_pkg::COORD_BITS-1:0];
        pt.px = px[ppg_pkg::COORD_BITS-1:0];
        pt.py = py[ppg_pkg::COORD_BITS-1:0];
        pt.pz = pz[ppg_pkg::COORD_BITS-1:0];
        pending_points.push_back(pt);
    endtask

    // mostly points close to a plausible ground triangle, plus noise,
    // degenerate triangles and corner values
    task automatic queue_random_point(input int spread);
        int ax, ay, az, ux, uy, uz, vx, vy, vz, k1, k2, pick;
        pick = $urandom_range(9);
        ax = pick_between(-4000000, 4000000);
        ay = pick_between(-4000000, 4000000);
        az = pick_between(-4000000, 4000000);
        ux = pick_between(-3000, 3000);
        uy = pick_between(-3000, 3000);
        uz = pick_between(-3000, 3000);
        vx = pick_between(-3000, 3000);
        vy = pick_between(-3000, 3000);
        vz = pick_between(-3000, 3000);
        k1 = pick_between(-4, 4);
        k2 = pick_between(-4, 4);
        if (pick <= 4)
        begin
            queue_point(ax, ay, az, ax + ux, ay + uy, az + uz, ax + vx, ay + vy, az + vz,
                        ax + k1 * ux + k2 * vx + pick_between(-spread, spread),
                        ay + k1 * uy + k2 * vy + pick_between(-spread, spread),
                        az + k1 * uz + k2 * vz + pick_between(-spread, spread));
        end
        else if (pick <= 7)
        begin
            queue_point(int'($urandom), int'($urandom), int'($urandom),
                        int'($urandom), int'($urandom), int'($urandom),
                        int'($urandom), int'($urandom), int'($urandom),
                        int'($urandom), int'($urandom), int'($urandom));
        end
        else if (pick == 8)
        begin
            // collinear or coincident vertices
            if ($urandom_range(1) == 0)
                queue_point(ax, ay, az, ax + ux, ay + uy, az + uz,
                            ax + k1 * ux, ay + k1 * uy, az + k1 * uz,
                            ax + vx, ay + vy, az + vz);
            else
                queue_point(ax, ay, az, ax, ay, az, ax + ux, ay + uy, az + uz,
                            ax + vx, ay + vy, az + vz);
        end
        else
        begin
            queue_point(corner_value(), corner_value(), corner_value(),
                        corner_value(), corner_value(), corner_value(),
                        corner_value(), corner_value(), corner_value(),
                        corner_value(), corner_value(), corner_value());
        end
    endtask

    task automatic write_reg(input logic [ppg_pkg::CFG_INDEX_BITS-1:0] index,
                             input logic [ppg_pkg::CFG_DATA_BITS-1:0] data);
        reg_write_t wr;
        wr.index = index;
        wr.data = data;
        pending_reg_writes.push_back(wr);
    endtask

    // new register settings, with junk in the unused upper bits
    task automatic configure_random();
        int thr;
        logic [ppg_pkg::CFG_DATA_BITS-1:0] data;
        case ($urandom_range(4))
            0: thr = 0;
            1: thr = pick_between(1, 64);
            2: thr = pick_between(100, 3000);
            3: thr = 1048575;
            default: thr = pick_between(0, 1048575);
        endcase
        cur_spread = (thr > 3000) ? 3000 : thr + 8;
        data = ppg_pkg::CFG_DATA_BITS'($urandom);
        data[ppg_pkg::THRESH_BITS-1:0] = thr[ppg_pkg::THRESH_BITS-1:0];
        write_reg(ppg_pkg::REG_DOOR_THRESHOLD, data);
        case ($urandom_range(2))
            0: data = CMAX[ppg_pkg::CFG_DATA_BITS-1:0];
            1: data = CMIN[ppg_pkg::CFG_DATA_BITS-1:0];
            default: data = ppg_pkg::CFG_DATA_BITS'($urandom);
        endcase
        write_reg(ppg_pkg::REG_CUT_HEIGHT, data);
        data = ppg_pkg::CFG_DATA_BITS'($urandom);
        write_reg(ppg_pkg::REG_CUT_ENABLE, data);
        if ($urandom_range(2) == 0)
            write_reg(REG_UNUSED, ppg_pkg::CFG_DATA_BITS'($urandom));
    endtask

    // wait until every request and write is through, then let the pipe settle
    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_points.size() != 0 || pending_reg_writes.size() != 0 || req_valid
               || cfg_valid || expected_verdicts.size() != 0);
        repeat (ppg_pkg::DEPTH + 4) @(posedge clk);
    endtask

    // driver for the request and register write channels
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req <= '0;
            cfg_valid <= 1'b0;
            cfg_index <= '0;
            cfg_data <= '0;
            send_gap <= 0;
        end
        else
        begin
            // register writes
            if (!(cfg_valid && !cfg_ready))
            begin
                if (pending_reg_writes.size() != 0)
                begin
                    cfg_valid <= 1'b1;
                    cfg_index <= pending_reg_writes[0].index;
                    cfg_data <= pending_reg_writes[0].data;
                    void'(pending_reg_writes.pop_front());
                end
                else
                    cfg_valid <= 1'b0;
            end
            // requests, each followed by its own drawn gap
            if (!(req_valid && !req_ready))
            begin
                if (send_gap != 0)
                begin
                    send_gap <= send_gap - 1;
                    req_valid <= 1'b0;
                end
                else if (pending_points.size() != 0)
                begin
                    req_valid <= 1'b1;
                    req <= pending_points.pop_front();
                    send_gap <= $urandom_range(sender_max_gap);
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // receiver with per-result stalls and an occasional long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
            rsp_stall <= 0;
            hold_left <= 0;
            hold_seen <= 0;
        end
        else if (hold_seen != hold_requests)
        begin
            hold_seen <= hold_requests;
            hold_left <= LONG_HOLD;
            rsp_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            rsp_ready <= (hold_left == 1);
        end
        else if (rsp_valid && rsp_ready)
        begin
            rsp_draw = $urandom_range(receiver_max_gap);
            rsp_stall <= rsp_draw;
            rsp_ready <= (rsp_draw == 0);
        end
        else if (rsp_stall != 0)
        begin
            rsp_stall <= rsp_stall - 1;
            rsp_ready <= (rsp_stall == 1);
        end
        else
            rsp_ready <= 1'b1;
    end

    // monitor: tracks register writes, predicts each request, checks each result
    always @(posedge clk)
    begin
        ppg_pkg::rsp_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    ppg_pkg::REG_DOOR_THRESHOLD:
                        door_limit = cfg_data[ppg_pkg::THRESH_BITS-1:0];
                    ppg_pkg::REG_CUT_HEIGHT:
                        cut_limit = cfg_data[ppg_pkg::CUT_BITS-1:0];
                    ppg_pkg::REG_CUT_ENABLE:
                        cut_on = cfg_data[0];
                    default: ;
                endcase
            end
            if (req_valid && req_ready)
                expected_verdicts.push_back(classify_point(req));
            if (rsp_valid && rsp_ready)
            begin
                if (expected_verdicts.size() == 0)
                begin
                    $error("result with no request outstanding");
                    mismatches++;
                end
                else
                begin
                    want = expected_verdicts.pop_front();
                    if (rsp.is_ground !== want.is_ground)
                    begin
                        $error("is_ground expected %0b actual %0b", want.is_ground,
                               rsp.is_ground);
                        mismatches++;
                    end
                    if (rsp.degenerate !== want.degenerate)
                    begin
                        $error("degenerate expected %0b actual %0b", want.degenerate,
                               rsp.degenerate);
                        mismatches++;
                    end
                end
            end
        end
    end

    // run limit
    initial
    begin
        #(TIMEOUT_TIME);
        $display("tb: FAIL");
        $finish;
    end

    // test sequence
    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: zero threshold, nothing is ground
        queue_point(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        queue_point(0, 0, 0, 1000, 0, 0, 0, 1000, 0, 5, 5, 0);
        queue_point(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX);
        queue_point(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN);
        queue_point(CMIN, CMIN, 0, CMAX, CMIN, 0, CMIN, CMAX, 0, CMAX, CMAX, CMAX);
        wait_idle();

        // threshold 1000 with junk upper bits, cut at zero enabled
        write_reg(ppg_pkg::REG_DOOR_THRESHOLD, 24'hF003E8);
        write_reg(ppg_pkg::REG_CUT_HEIGHT, 24'h000000);
        write_reg(ppg_pkg::REG_CUT_ENABLE, 24'hFFFFFF);
        write_reg(REG_UNUSED, 24'hABCDEF);
        wait_idle();
        // flat plane at z -5000: on plane, just inside, on the limit, outside
        queue_point(0, 0, -5000, 1000, 0, -5000, 0, 1000, -5000, 10, 10, -5000);
        queue_point(0, 0, -5000, 1000, 0, -5000, 0, 1000, -5000, 10, 10, -4001);
        queue_point(0, 0, -5000, 1000, 0, -5000, 0, 1000, -5000, 10, 10, -4000);
        queue_point(0, 0, -5000, 1000, 0, -5000, 0, 1000, -5000, 10, 10, -6001);
        // height equal to the cut, then just under it
        queue_point(0, 0, 0, 1000, 0, 0, 0, 1000, 0, 3, 3, 0);
        queue_point(0, 0, 0, 1000, 0, 0, 0, 1000, 0, 3, 3, -1);
        // collinear and coincident vertices
        queue_point(0, 0, 0, 10, 20, 30, 20, 40, 60, 0, 0, 0);
        queue_point(7, 7, 7, 7, 7, 7, 100, -50, 3, 7, 7, 7);
        // tilted plane with unit normal (-4, 0, 3) / 5
        queue_point(0, 0, 0, 3, 0, 4, 0, 1, 0, 796, 0, -597);
        queue_point(0, 0, 0, 3, 0, 4, 0, 1, 0, 800, 0, -600);
        wait_idle();

        // largest threshold, lowest cut
        write_reg(ppg_pkg::REG_DOOR_THRESHOLD, 24'hFFFFFF);
        write_reg(ppg_pkg::REG_CUT_HEIGHT, 24'h800000);
        write_reg(ppg_pkg::REG_CUT_ENABLE, 24'h000001);
        wait_idle();
        queue_point(0, 0, -5000, 1000, 0, -5000, 0, 1000, -5000, 10, 10, -5000);
        queue_point(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN);
        wait_idle();

        // cut disabled through bit 0 only, highest cut
        write_reg(ppg_pkg::REG_CUT_ENABLE, 24'hFFFFFE);
        write_reg(ppg_pkg::REG_CUT_HEIGHT, 24'h7FFFFF);
        wait_idle();
        queue_point(0, 0, -5000, 1000, 0, -5000, 0, 1000, -5000, 10, 10, -5000);
        queue_point(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN);
        queue_point(CMIN, CMIN, CMIN, CMAX, CMIN, CMIN, CMIN, CMAX, CMIN, CMAX, CMAX, CMAX);
        wait_idle();

        // random phases, each with its own settings and idling pattern
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0:
                begin
                    sender_max_gap = 0;
                    receiver_max_gap = 0;
                end
                1:
                begin
                    sender_max_gap = 18;
                    receiver_max_gap = 18;
                end
                2:
                begin
                    sender_max_gap = 0;
                    receiver_max_gap = 3;
                end
                3:
                begin
                    sender_max_gap = 18;
                    receiver_max_gap = 0;
                end
                4:
                begin
                    sender_max_gap = 0;
                    receiver_max_gap = 18;
                end
                default:
                begin
                    sender_max_gap = 6;
                    receiver_max_gap = 6;
                end
            endcase
            configure_random();
            wait_idle();
            // back-pressure: receiver holds off while requests keep coming
            if (phase == 2)
                hold_requests = hold_requests + 1;
            repeat (75) queue_random_point(cur_spread);
            wait_idle();
        end

        if (mismatches == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
